[rtl/core/imucf_pkg.sv]
`default_nettype none
package imucf_pkg;

  localparam int unsigned TAB_LEN = 24;
  localparam logic signed [31:0] PI_Q16 = 32'sd205887;

  typedef enum logic [1:0] {
    REG_RATE_GAIN  = 2'd0,
    REG_STEP_GAIN  = 2'd1,
    REG_BLEND      = 2'd2,
    REG_LIMIT      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_CORDIC,
    ST_BLEND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } lane_ctl_t;

  function automatic logic signed [31:0] atan_tab(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0: v = 32'sd51472;
      5'd1: v = 32'sd30385;
      5'd2: v = 32'sd16055;
      5'd3: v = 32'sd8150;
      5'd4: v = 32'sd4091;
      5'd5: v = 32'sd2047;
      5'd6: v = 32'sd1024;
      5'd7: v = 32'sd512;
      5'd8: v = 32'sd256;
      5'd9: v = 32'sd128;
      5'd10: v = 32'sd64;
      5'd11: v = 32'sd32;
      5'd12: v = 32'sd16;
      5'd13: v = 32'sd8;
      5'd14: v = 32'sd4;
      5'd15: v = 32'sd2;
      5'd16: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -64'sh80000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/imucf_if.sv]
`default_nettype none
interface imucf_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_pitch;
  logic signed [15:0] gyro_yaw;
  logic signed [15:0] gyro_roll;
  modport source (output valid, accel_x, accel_y, accel_z, gyro_pitch, gyro_yaw,
    gyro_roll, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, gyro_pitch, gyro_yaw,
    gyro_roll, output ready);
endinterface

interface imucf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] yaw_angle;
  logic signed [31:0] pitch_angle;
  logic signed [31:0] roll_angle;
  logic signed [31:0] yaw_rate;
  logic signed [31:0] pitch_rate;
  logic signed [31:0] roll_rate;
  logic blended;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, yaw_rate,
    pitch_rate, roll_rate, blended, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, yaw_rate,
    pitch_rate, roll_rate, blended, output ready);
endinterface
`default_nettype wire

[rtl/core/imucf_isqrt.sv]
`default_nettype none
module imucf_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [33:0] value,
  output imucf_pkg::lane_ctl_t ctl,
  output logic [16:0]      root
);
  logic [33:0] rem;
  logic [33:0] res;
  logic [33:0] bitv;
  logic        busy;
  logic        done;
  logic [33:0] trial;

  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= value;
        res  <= '0;
        bitv <= 34'h1 << 32;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res[16:0];
  assign ctl.start = start;
  assign ctl.busy = busy;
  assign ctl.done = done;

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("root done w/o busy");
  a_not_both: assert property (@(posedge clk) disable iff (rst) !(done && busy))
    else $error("root done while busy");
  a_root_range: assert property (@(posedge clk) disable iff (rst) done |-> res[33:17] == '0)
    else $error("root too wide");
endmodule
`default_nettype wire

[rtl/core/imucf_cordic.sv]
`default_nettype none
module imucf_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [17:0] y_in,
  input  wire logic signed [17:0] x_in,
  output imucf_pkg::lane_ctl_t    ctl,
  output logic signed [31:0]      angle
);
  localparam int unsigned NSTEP = (CORDIC_STEPS < imucf_pkg::TAB_LEN) ?
                                  CORDIC_STEPS : imucf_pkg::TAB_LEN;
  logic signed [40:0] x, y;
  logic signed [31:0] z;
  logic [4:0] i;
  logic busy, done;
  logic signed [40:0] xs, ys;
  logic signed [40:0] x0, y0;

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign x0 = 41'(x_in) <<< 14;
  assign y0 = 41'(y_in) <<< 14;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        i <= '0;
        if (x_in == 0 && y_in == 0) begin
          x <= '0;
          y <= '0;
          z <= '0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          if (x_in < 0) begin
            z <= (y_in >= 0) ? imucf_pkg::PI_Q16 : -imucf_pkg::PI_Q16;
            x <= -x0;
            y <= -y0;
          end else begin
            z <= '0;
            x <= x0;
            y <= y0;
          end
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + imucf_pkg::atan_tab(i);
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - imucf_pkg::atan_tab(i);
        end
        i <= i + 5'd1;
        if (i == 5'(NSTEP - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign angle = z;
  assign ctl.start = start;
  assign ctl.busy = busy;
  assign ctl.done = done;

  a_step_bound: assert property (@(posedge clk) disable iff (rst) busy |-> i < 5'(NSTEP))
    else $error("cordic step overrun");
  a_not_both: assert property (@(posedge clk) disable iff (rst) !(done && busy))
    else $error("cordic done while busy");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("cordic restarted while busy");
endmodule
`default_nettype wire

[rtl/core/imu_complementary_filter.sv]
`default_nettype none
// Six-axis complementary attitude filter. Each accepted input beat yields one
// output beat. Three lanes each run a bit-serial square root (17 steps) then a
// CORDIC atan2 (CORDIC_STEPS steps, capped at TAB_LEN); a fourth root gives the
// total magnitude. A merge stage applies the blend one axis at a time when that
// magnitude is below accel_limit. Output stalls lengthen the time a sample
// occupies the block. The block takes one sample at a time. Configuration
// registers at byte addresses 0, 4, 8, 12 (rate_gain, step_gain, blend_coeff,
// accel_limit).
module imu_complementary_filter #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned SAMPLE_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  imucf_in_if.sink         s_in,
  imucf_out_if.source      m_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [31:0] rate_gain, step_gain;
  logic [15:0] blend_coeff, accel_limit;
  imucf_pkg::reg_idx_t ridx;
  assign ridx = imucf_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_gain <= 32'd573;
      step_gain <= 32'd6;
      blend_coeff <= 16'd62259;
      accel_limit <= 16'd16384;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (ridx)
        imucf_pkg::REG_RATE_GAIN: rate_gain <= pwdata;
        imucf_pkg::REG_STEP_GAIN: step_gain <= pwdata;
        imucf_pkg::REG_BLEND:     blend_coeff <= pwdata[15:0];
        imucf_pkg::REG_LIMIT:     accel_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      imucf_pkg::REG_RATE_GAIN: prdata = rate_gain;
      imucf_pkg::REG_STEP_GAIN: prdata = step_gain;
      imucf_pkg::REG_BLEND:     prdata = {16'd0, blend_coeff};
      imucf_pkg::REG_LIMIT:     prdata = {16'd0, accel_limit};
      default:                  prdata = '0;
    endcase
  end

  imucf_pkg::state_t state, state_next;
  logic [3:0] cnt;
  logic signed [15:0] ax, ay, az;
  logic signed [15:0] g [3];
  logic signed [31:0] ang [3];
  logic signed [31:0] rate [3];
  logic signed [31:0] oang [3];
  logic        oblend;
  logic [31:0] sx, sy, sz;

  logic signed [48:0] prod;
  logic [1:0]  k;
  logic signed [48:0] gext;
  logic signed [48:0] sgain;
  assign gext = 49'(g[k]);
  assign sgain = {17'd0, cnt[0] ? step_gain : rate_gain};
  assign prod = gext * sgain;

  logic        sq_start;
  logic [33:0] sq_val [4];
  logic [16:0] root [4];
  imucf_pkg::lane_ctl_t sq_ctl [4];
  logic        co_start;
  logic signed [17:0] co_y [3], co_x [3];
  logic signed [31:0] acc_ang [3];
  imucf_pkg::lane_ctl_t co_ctl [3];

  assign sq_val[0] = 34'(sx) + 34'(sy);
  assign sq_val[1] = 34'(sx) + 34'(sz);
  assign sq_val[2] = 34'(sy) + 34'(sz);
  assign sq_val[3] = 34'(sx) + 34'(sy) + 34'(sz);
  assign co_y[0] = 18'(signed'({1'b0, root[0]}));
  assign co_x[0] = 18'(az);
  assign co_y[1] = 18'(ay);
  assign co_x[1] = 18'(signed'({1'b0, root[1]}));
  assign co_y[2] = 18'(ax);
  assign co_x[2] = 18'(signed'({1'b0, root[2]}));

  for (genvar l = 0; l < 4; l++) begin : g_sq
    imucf_isqrt u_sq (.clk, .rst, .start(sq_start), .value(sq_val[l]),
      .ctl(sq_ctl[l]), .root(root[l]));
  end
  for (genvar l = 0; l < 3; l++) begin : g_co
    imucf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_co (.clk, .rst, .start(co_start),
      .y_in(co_y[l]), .x_in(co_x[l]), .ctl(co_ctl[l]), .angle(acc_ang[l]));
  end

  logic co_done_all;
  assign co_done_all = co_ctl[0].done;
  logic blend_now;
  assign blend_now = {15'd0, root[3]} < 32'(accel_limit);

  logic signed [48:0] mix;
  logic signed [31:0] bang;
  assign mix = 49'(ang[k]) * 49'(signed'({1'b0, blend_coeff}))
             + 49'(acc_ang[k]) * 49'(signed'(18'(32'd65536 - 32'(blend_coeff))));
  assign bang = imucf_pkg::sat32(64'(mix >>> 16));

  logic signed [63:0] incr_sum;
  assign incr_sum = 64'(ang[k]) + 64'(imucf_pkg::sat32(64'(prod >>> SAMPLE_BITS)));

  assign s_in.ready = (state == imucf_pkg::ST_IDLE);
  assign sq_start = (state == imucf_pkg::ST_SQRT) && (cnt == 4'd0);
  assign co_start = (state == imucf_pkg::ST_SQRT) && sq_ctl[0].done;

  always_comb begin
    state_next = state;
    unique case (state)
      imucf_pkg::ST_IDLE:   if (s_in.valid) state_next = imucf_pkg::ST_SQRT;
      imucf_pkg::ST_SQRT:   if (sq_ctl[0].done) state_next = imucf_pkg::ST_CORDIC;
      imucf_pkg::ST_CORDIC: if (co_done_all) state_next = imucf_pkg::ST_BLEND;
      imucf_pkg::ST_BLEND:  if (k == 2'd2) state_next = imucf_pkg::ST_OUT;
      imucf_pkg::ST_OUT:    if (m_out.ready) state_next = imucf_pkg::ST_IDLE;
      default:              state_next = imucf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imucf_pkg::ST_IDLE;
      for (int j = 0; j < 3; j++) ang[j] <= '0;
      cnt <= '0;
      k <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        imucf_pkg::ST_IDLE: begin
          cnt <= '0;
          k <= '0;
          if (s_in.valid) begin
            ax <= s_in.accel_x;
            ay <= s_in.accel_y;
            az <= s_in.accel_z;
            g[0] <= s_in.gyro_yaw;
            g[1] <= s_in.gyro_pitch;
            g[2] <= s_in.gyro_roll;
            sx <= 32'(s_in.accel_x * s_in.accel_x);
            sy <= 32'(s_in.accel_y * s_in.accel_y);
            sz <= 32'(s_in.accel_z * s_in.accel_z);
          end
        end
        imucf_pkg::ST_SQRT, imucf_pkg::ST_CORDIC: begin
          if (cnt < 4'd6) begin
            if (!cnt[0]) begin
              rate[k] <= imucf_pkg::sat32(64'(prod >>> 16));
            end else begin
              ang[k] <= imucf_pkg::sat32(incr_sum);
              k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
            end
            cnt <= cnt + 4'd1;
          end
          if (co_done_all) k <= '0;
        end
        imucf_pkg::ST_BLEND: begin
          oblend <= blend_now;
          if (blend_now) begin
            ang[k] <= bang;
            oang[k] <= bang;
          end else begin
            oang[k] <= ang[k];
          end
          k <= k + 2'd1;
        end
        imucf_pkg::ST_OUT: ;
        default: ;
      endcase
    end
  end

  assign m_out.valid = (state == imucf_pkg::ST_OUT);
  assign m_out.yaw_angle = oang[0];
  assign m_out.pitch_angle = oang[1];
  assign m_out.roll_angle = oang[2];
  assign m_out.yaw_rate = rate[0];
  assign m_out.pitch_rate = rate[1];
  assign m_out.roll_rate = rate[2];
  assign m_out.blended = oblend;

  a_out_idle: assert property (@(posedge clk) disable iff (rst) m_out.valid |-> !s_in.ready)
    else $error("accept while result pending");
  a_lanes_sync: assert property (@(posedge clk) disable iff (rst)
    sq_ctl[0].done |-> (sq_ctl[3].done && sq_ctl[1].done && sq_ctl[2].done))
    else $error("root lanes out of step");
  a_co_sync: assert property (@(posedge clk) disable iff (rst)
    co_ctl[0].done |-> (co_ctl[1].done && co_ctl[2].done))
    else $error("cordic lanes out of step");
endmodule
`default_nettype wire

[test/imucf_filter_check.sv]
module imucf_filter_check (
  input  wire logic   clk,
  input  wire logic   rst,
  imucf_in_if         s_in,
  imucf_out_if        m_out,
  input  wire logic [31:0] rate_gain,
  input  wire logic [31:0] step_gain,
  input  wire logic [15:0] blend_coeff,
  input  wire logic [15:0] accel_limit,
  output int          errors,
  output int          pending
);
  localparam int STEPS = 16;
  localparam int SBITS = 16;

  typedef struct packed {
    logic signed [31:0] yaw_angle;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] roll_angle;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] roll_rate;
    logic blended;
  } attitude_t;

  attitude_t attitude_q[$];
  longint heading[3];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint root(longint n);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint arctan_step(int i);
    case (i)
      0: return 51472;  1: return 30385;  2: return 16055;  3: return 8150;
      4: return 4091;   5: return 2047;   6: return 1024;   7: return 512;
      8: return 256;    9: return 128;    10: return 64;    11: return 32;
      12: return 16;    13: return 8;     14: return 4;     15: return 2;
      16: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + arctan_step(i);
      end else begin
        x = x - ys; y = y + xs; z = z - arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic attitude_t fuse_sample(longint ax, longint ay, longint az,
                                            longint gp, longint gy, longint gr);
    attitude_t a;
    longint g[3];
    longint rt[3];
    longint tilt[3];
    longint sx;
    longint sy;
    longint sz;
    longint c;
    logic bl;
    g[0] = gy; g[1] = gp; g[2] = gr;
    sx = ax * ax; sy = ay * ay; sz = az * az;
    for (int k = 0; k < 3; k++) begin
      rt[k] = clip32(fshift(g[k] * longint'(rate_gain), 16));
      heading[k] = clip32(heading[k] + clip32(fshift(g[k] * longint'(step_gain), SBITS)));
    end
    tilt[0] = vector_angle(root(sx + sy), az);
    tilt[1] = vector_angle(ay, root(sx + sz));
    tilt[2] = vector_angle(ax, root(sy + sz));
    bl = root(sx + sy + sz) < longint'(accel_limit);
    if (bl) begin
      c = longint'(blend_coeff);
      for (int k = 0; k < 3; k++)
        heading[k] = clip32(fshift(heading[k] * c + tilt[k] * (65536 - c), 16));
    end
    a.yaw_angle = heading[0]; a.pitch_angle = heading[1]; a.roll_angle = heading[2];
    a.yaw_rate = rt[0]; a.pitch_rate = rt[1]; a.roll_rate = rt[2];
    a.blended = bl;
    return a;
  endfunction

  always @(posedge clk) begin
    attitude_t got;
    attitude_t want;
    if (rst) begin
      heading[0] = 0; heading[1] = 0; heading[2] = 0;
      errors <= 0;
      pending <= 0;
    end else begin
      if (s_in.valid && s_in.ready)
        attitude_q.push_back(fuse_sample(s_in.accel_x, s_in.accel_y, s_in.accel_z,
          s_in.gyro_pitch, s_in.gyro_yaw, s_in.gyro_roll));
      if (m_out.valid && m_out.ready) begin
        got = {m_out.yaw_angle, m_out.pitch_angle, m_out.roll_angle, m_out.yaw_rate,
               m_out.pitch_rate, m_out.roll_rate, m_out.blended};
        if (attitude_q.size() == 0) begin
          $display("%0t unexpected beat %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = attitude_q.pop_front();
          if (got !== want) begin
            $display("%0t mismatch exp ya=%0d pa=%0d ra=%0d yr=%0d pr=%0d rr=%0d b=%0d",
              $time, want.yaw_angle, want.pitch_angle, want.roll_angle,
              want.yaw_rate, want.pitch_rate, want.roll_rate, want.blended);
            $display("%0t          got ya=%0d pa=%0d ra=%0d yr=%0d pr=%0d rr=%0d b=%0d",
              $time, got.yaw_angle, got.pitch_angle, got.roll_angle,
              got.yaw_rate, got.pitch_rate, got.roll_rate, got.blended);
            errors <= errors + 1;
          end
        end
      end
      pending <= attitude_q.size();
    end
  end
endmodule

[test/imu_complementary_filter_tb.sv]
module imu_complementary_filter_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic [31:0] rate_gain = 32'd573;
  logic [31:0] step_gain = 32'd6;
  logic [15:0] blend_coeff = 16'd62259;
  logic [15:0] accel_limit = 16'd16384;
  int errors;
  int pending;
  longint cycles = 0;
  logic stall_mode = 1'b0;

  imucf_in_if s_in ();
  imucf_out_if m_out ();

  imu_complementary_filter i_dut (
    .clk(clk), .rst(rst), .s_in(s_in.sink), .m_out(m_out.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  imucf_filter_check i_check (
    .clk(clk), .rst(rst), .s_in(s_in), .m_out(m_out),
    .rate_gain(rate_gain), .step_gain(step_gain), .blend_coeff(blend_coeff),
    .accel_limit(accel_limit), .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("[imu_complementary_filter] ERROR");
      $finish;
    end
  end

  initial begin
    s_in.valid = 1'b0;
    s_in.accel_x = '0; s_in.accel_y = '0; s_in.accel_z = '0;
    s_in.gyro_pitch = '0; s_in.gyro_yaw = '0; s_in.gyro_roll = '0;
    m_out.ready = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_mode) m_out.ready <= ($urandom_range(0, 3) != 0);
    else m_out.ready <= 1'b1;
    if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
  end

  task automatic write_reg(imucf_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      imucf_pkg::REG_RATE_GAIN: rate_gain <= value;
      imucf_pkg::REG_STEP_GAIN: step_gain <= value;
      imucf_pkg::REG_BLEND:     blend_coeff <= value[15:0];
      imucf_pkg::REG_LIMIT:     accel_limit <= value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] gp, logic [15:0] gy, logic [15:0] gr);
    s_in.valid <= 1'b1;
    s_in.accel_x <= ax; s_in.accel_y <= ay; s_in.accel_z <= az;
    s_in.gyro_pitch <= gp; s_in.gyro_yaw <= gy; s_in.gyro_roll <= gr;
    do @(posedge clk); while (!s_in.ready);
    @(negedge clk);
  endtask

  task automatic go_idle();
    s_in.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic random_sample();
    logic [15:0] a[3];
    int mode;
    mode = $urandom_range(0, 3);
    for (int k = 0; k < 3; k++) begin
      if (mode == 0) a[k] = 16'($urandom);
      else if (mode == 1) a[k] = 16'($signed($urandom_range(0, 8000)) - 4000);
      else if (mode == 2) a[k] = (k == 2) ? 16'd16384 : 16'($urandom_range(0, 511) - 256);
      else a[k] = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
    end
    send_sample(a[0], a[1], a[2], 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && count > 0) begin
        random_sample();
        burst--; count--;
      end
      if ($urandom_range(0, 1)) begin
        s_in.valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h0000, 16'h0000, 16'h4000, 16'h0100, 16'hff00, 16'h0010);
    send_sample(16'h0000, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h1000, 16'hf000, 16'h0000, 16'h8000, 16'h7fff, 16'hffff);
    send_sample(16'hffff, 16'h0001, 16'h0000, 16'h0001, 16'hffff, 16'h8000);
    go_idle();
    write_reg(imucf_pkg::REG_BLEND, 32'd0);
    write_reg(imucf_pkg::REG_LIMIT, 32'd65535);
    write_reg(imucf_pkg::REG_RATE_GAIN, 32'hffffffff);
    write_reg(imucf_pkg::REG_STEP_GAIN, 32'hffffffff);
    send_sample(16'h0100, 16'h0200, 16'h0300, 16'h7fff, 16'h8000, 16'h1234);
    send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
    random_phase(250);
    go_idle();
    write_reg(imucf_pkg::REG_BLEND, 32'd65535);
    write_reg(imucf_pkg::REG_LIMIT, 32'd0);
    write_reg(imucf_pkg::REG_RATE_GAIN, 32'd0);
    write_reg(imucf_pkg::REG_STEP_GAIN, 32'd0);
    random_phase(250);
    go_idle();
    write_reg(imucf_pkg::REG_BLEND, 32'd62259);
    write_reg(imucf_pkg::REG_LIMIT, 32'd56756);
    write_reg(imucf_pkg::REG_RATE_GAIN, 32'd573);
    write_reg(imucf_pkg::REG_STEP_GAIN, 32'd65536);
    random_phase(300);
    go_idle();
    write_reg(imucf_pkg::REG_BLEND, $urandom_range(0, 65535));
    write_reg(imucf_pkg::REG_LIMIT, $urandom_range(0, 56756));
    write_reg(imucf_pkg::REG_RATE_GAIN, $urandom);
    write_reg(imucf_pkg::REG_STEP_GAIN, $urandom);
    random_phase(300);
    go_idle();
    if (errors == 0 && pending == 0) begin
      $display("[imu_complementary_filter] OK");
    end else begin
      $display("[imu_complementary_filter] ERROR");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/imucf_pkg.sv
rtl/core/imucf_if.sv
rtl/core/imucf_isqrt.sv
rtl/core/imucf_cordic.sv
rtl/core/imu_complementary_filter.sv
test/imucf_filter_check.sv
test/imu_complementary_filter_tb.sv
